/* design/stp_pkg.sv */
// Shared types, constants and helpers for the spanning tree BPDU engine.
`default_nettype none
package stp_pkg;
  localparam int NP = 8;
  localparam int IW = $clog2(NP);
  localparam int CW = IW + 1;
  localparam int TDW = 184;

  typedef struct packed {
    logic [63:0] root;
    logic [31:0] cost;
    logic [63:0] bridge;
    logic [15:0] port;
  } vec_t;

  localparam logic [1:0] REG_BRIDGE = 2'd0;
  localparam logic [1:0] REG_COST   = 2'd1;
  localparam logic [1:0] REG_PRIO   = 2'd2;
  localparam logic [1:0] REG_PORTS  = 2'd3;

  function automatic logic [15:0] own_pid(input logic [7:0] prio, input logic [IW-1:0] i);
    own_pid = {prio, 8'(i) + 8'd1};
  endfunction
endpackage
`default_nettype wire

/* design/spanning_tree_bpdu_engine.sv */
// Spanning tree config BPDU engine: port vector table, root port selection, hello.
// Usage: one slave stream carries events (tuser = func: 0 received config BPDU,
// 1 hello tick); one master stream carries BPDUs to send, tlast on the last
// BPDU an event causes. The plain write port (cfg_we, cfg_index, cfg_data)
// sets bridge_id, link_cost, port_priority, ports_in_use; any valid write
// reinitialises the port table. Write only while the block is idle.
// Timing: one event at a time through a sequencer sharing one vector
// comparator, one table entry per cycle. A hello tick scans the table, then
// sends one BPDU per designated port. A received BPDU is answered or stored;
// if stored, root selection and refresh follow. s_tready is high only when idle.
// Stall: a BPDU is held in the output register until taken; the sequencer
// waits on it and no beat is lost. Reset (rst, synchronous) restores the
// register defaults and the table; no clearing pass is needed.
`default_nettype none
module spanning_tree_bpdu_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // port_index[2:0], rx_root_id[66:3], rx_root_cost[98:67],
  // rx_bridge_id[162:99], rx_port_id[178:163], zero fill
  input  logic [stp_pkg::TDW-1:0] s_tdata,
  input  logic                    s_tuser, // func
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // out_port[2:0], tx_root_id[66:3], tx_root_cost[98:67],
  // tx_bridge_id[162:99], tx_port_id[178:163], zero fill
  output logic [stp_pkg::TDW-1:0] m_tdata,
  output logic                    m_tlast,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [63:0]             cfg_data
);
  import stp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HSCAN = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_RXCMP = 3'd3;
  localparam logic [2:0] S_SEL   = 3'd4;
  localparam logic [2:0] S_NODE  = 3'd5;
  localparam logic [2:0] S_REF   = 3'd6;

  logic [2:0]    state;
  logic [63:0]   bridge_id;
  logic [15:0]   link_cost;
  logic [7:0]    port_priority;
  logic [3:0]    ports_in_use;
  vec_t          tbl [NP];
  logic [63:0]   node_root;
  logic [31:0]   node_cost;
  logic          root_port_valid;
  logic [IW-1:0] root_port_index;
  logic [IW-1:0] idx;
  logic [NP-1:0] mask;
  vec_t          rx;
  vec_t          best;
  logic [IW-1:0] best_idx;
  logic          found;

  vec_t          cur, sv, cmp_a, cmp_b;
  logic          lt, desig_cur, last_idx, may_send, out_free, elig, emit_go;
  logic [CW-1:0] n_act;
  logic [IW-1:0] low_idx;
  logic [32:0]   cost_sum;
  logic [63:0]   b_new;
  logic [7:0]    pp_new;

  assign n_act = (ports_in_use > 4'(NP)) ? CW'(NP) : CW'(ports_in_use);
  assign cur = tbl[idx];
  assign desig_cur = (cur.bridge == bridge_id) && (cur.port == own_pid(port_priority, idx));
  assign last_idx = ((CW'(idx) + CW'(1)) == n_act);
  assign may_send = (node_root == bridge_id) || root_port_valid;
  assign out_free = !m_tvalid || m_tready;
  assign emit_go = (state == S_EMIT) && (mask != '0) && out_free;
  assign sv = '{root: node_root, cost: node_cost, bridge: bridge_id,
                port: own_pid(port_priority, idx)};
  assign elig = !desig_cur && (cur.root < bridge_id);
  assign cost_sum = {1'b0, best.cost} + 33'(link_cost);
  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmp_a = cur;
    cmp_b = rx;
    case (state)
      S_SEL: begin
        cmp_a = cur;
        cmp_b = best;
      end
      S_REF: begin
        cmp_a = sv;
        cmp_b = cur;
      end
      default: begin
        cmp_a = cur;
        cmp_b = rx;
      end
    endcase
  end

  stp_vcmp u_vcmp (.a(cmp_a), .b(cmp_b), .lt(lt));

  always_comb begin
    low_idx = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (mask[i]) low_idx = IW'(i);
    end
  end

  always_comb begin
    b_new = bridge_id;
    pp_new = port_priority;
    if (cfg_we && cfg_index == REG_BRIDGE) b_new = cfg_data;
    if (cfg_we && cfg_index == REG_PRIO) pp_new = cfg_data[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int i = 0; i < NP; i++) begin
        tbl[i] <= '{root: rst ? 64'd0 : b_new, cost: 32'd0,
                    bridge: rst ? 64'd0 : b_new,
                    port: own_pid(rst ? 8'd128 : pp_new, IW'(i))};
      end
      node_root <= rst ? 64'd0 : b_new;
      node_cost <= '0;
      root_port_valid <= 1'b0;
      root_port_index <= '0;
      if (rst) begin
        bridge_id <= '0;
        link_cost <= 16'd1;
        port_priority <= 8'd128;
        ports_in_use <= 4'd8;
        state <= S_IDLE;
        m_tvalid <= 1'b0;
      end else begin
        bridge_id <= b_new;
        port_priority <= pp_new;
        if (cfg_index == REG_COST) link_cost <= cfg_data[15:0];
        if (cfg_index == REG_PORTS) ports_in_use <= cfg_data[3:0];
      end
    end else begin
      if (emit_go) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            rx <= '{root: s_tdata[66:3], cost: s_tdata[98:67],
                    bridge: s_tdata[162:99], port: s_tdata[178:163]};
            mask <= '0;
            if (s_tuser) begin
              idx <= '0;
              if (may_send && n_act != '0) state <= S_HSCAN;
            end else begin
              idx <= IW'(s_tdata[2:0]);
              if (CW'(s_tdata[2:0]) < n_act) state <= S_RXCMP;
            end
          end
        end
        S_HSCAN: begin
          mask[idx] <= desig_cur;
          if (last_idx) state <= S_EMIT;
          else idx <= idx + IW'(1);
        end
        S_EMIT: begin
          if (mask == '0) begin
            state <= S_IDLE;
          end else if (out_free) begin
            m_tdata <= {5'd0, own_pid(port_priority, low_idx), bridge_id, node_cost,
                        node_root, 3'(low_idx)};
            m_tlast <= ((mask & ~(NP'(1) << low_idx)) == '0);
            mask[low_idx] <= 1'b0;
          end
        end
        S_RXCMP: begin
          if (lt) begin
            if (may_send) begin
              mask[idx] <= 1'b1;
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            tbl[idx] <= rx;
            idx <= '0;
            found <= 1'b0;
            state <= S_SEL;
          end
        end
        S_SEL: begin
          if (elig && (!found || lt)) begin
            best <= cur;
            best_idx <= idx;
            found <= 1'b1;
          end
          if (last_idx) state <= S_NODE;
          else idx <= idx + IW'(1);
        end
        S_NODE: begin
          root_port_valid <= found;
          root_port_index <= found ? best_idx : '0;
          node_root <= found ? best.root : bridge_id;
          node_cost <= !found ? 32'd0 : (cost_sum[32] ? 32'hFFFF_FFFF : cost_sum[31:0]);
          idx <= '0;
          state <= S_REF;
        end
        S_REF: begin
          if (!(root_port_valid && idx == root_port_index) && (desig_cur || lt))
            tbl[idx] <= sv;
          if (last_idx) state <= S_IDLE;
          else idx <= idx + IW'(1);
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/stp_vcmp.sv */
// Shared priority vector comparator: field-wise ordering, lower is better.
`default_nettype none
module stp_vcmp (
  input  stp_pkg::vec_t a,
  input  stp_pkg::vec_t b,
  output logic          lt
);
  import stp_pkg::*;
  // packed struct order gives root, cost, bridge, port significance
  assign lt = a < b;
endmodule
`default_nettype wire

/* design/stp_chk.sv */
// Port-level checks for the BPDU engine, bound to the top level.
`default_nettype none
module stp_chk (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tvalid,
  input logic                    s_tready,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [stp_pkg::TDW-1:0] m_tdata
);
  import stp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("output beat dropped");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("output beat changed");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TDW-1:179] == '0) else $error("fill bits set");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready) else $error("bad state after reset");
endmodule

bind spanning_tree_bpdu_engine stp_chk u_stp_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

/* sim/stp_bpdu_checker.sv */
// Checker for the BPDU engine: tracks the port vector table, predicts BPDUs, compares.
`default_nettype none
module stp_bpdu_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [stp_pkg::TDW-1:0] s_tdata,
  input  logic                    s_tuser,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [stp_pkg::TDW-1:0] m_tdata,
  input  logic                    m_tlast,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [63:0]             cfg_data,
  output int                      errors,
  output int                      pending
);
  import stp_pkg::*;

  typedef struct packed {
    logic [2:0]  port;
    logic [63:0] root;
    logic [31:0] cost;
    logic [63:0] bridge;
    logic [15:0] pid;
    logic        last;
  } bpdu_t;

  bpdu_t bpdu_q[$];

  logic [63:0] own_bridge;
  logic [15:0] lcost;
  logic [7:0]  prio;
  logic [3:0]  nports;
  vec_t        tbl[8];
  logic [63:0] sw_root;
  logic [31:0] sw_cost;
  logic        rp_valid;
  logic [2:0]  rp_idx;

  assign pending = bpdu_q.size();

  function automatic logic [15:0] pid_of(int i);
    return {prio, 8'(i + 1)};
  endfunction

  // -1 a better, 1 worse, 0 equal
  function automatic int vcmp(vec_t a, vec_t b);
    if (a.root != b.root) return a.root < b.root ? -1 : 1;
    if (a.cost != b.cost) return a.cost < b.cost ? -1 : 1;
    if (a.bridge != b.bridge) return a.bridge < b.bridge ? -1 : 1;
    if (a.port != b.port) return a.port < b.port ? -1 : 1;
    return 0;
  endfunction

  function automatic bit desig(int i);
    return tbl[i].bridge == own_bridge && tbl[i].port == pid_of(i);
  endfunction

  function automatic int active();
    return nports > 8 ? 8 : int'(nports);
  endfunction

  task automatic clear_table();
    for (int i = 0; i < 8; i++) tbl[i] = '{own_bridge, 32'd0, own_bridge, pid_of(i)};
    sw_root = own_bridge;
    sw_cost = '0;
    rp_valid = 1'b0;
    rp_idx = '0;
  endtask

  task automatic push_bpdu(int i, bit last);
    bpdu_t b;
    b = '{3'(i), sw_root, sw_cost, own_bridge, pid_of(i), last};
    bpdu_q.push_back(b);
  endtask

  task automatic predict_event(logic func, logic [TDW-1:0] d);
    int n, k, best, first;
    bit found;
    vec_t rx, sv;
    logic [32:0] c;
    n = active();
    if (func) begin
      if (!(sw_root == own_bridge || rp_valid)) return;
      k = 0;
      for (int i = 0; i < n; i++) if (desig(i)) k++;
      first = 0;
      for (int i = 0; i < n; i++) if (desig(i)) begin
        first++;
        push_bpdu(i, first == k);
      end
      return;
    end
    if (int'(d[2:0]) >= n) return;
    rx = '{d[66:3], d[98:67], d[162:99], d[178:163]};
    if (vcmp(tbl[d[2:0]], rx) < 0) begin
      if (sw_root == own_bridge || rp_valid) push_bpdu(d[2:0], 1'b1);
      return;
    end
    tbl[d[2:0]] = rx;
    found = 0;
    best = 0;
    for (int i = 0; i < n; i++) begin
      if (desig(i) || tbl[i].root >= own_bridge) continue;
      if (!found || vcmp(tbl[i], tbl[best]) < 0) begin
        best = i;
        found = 1;
      end
    end
    if (found) begin
      c = {1'b0, tbl[best].cost} + lcost;
      rp_valid = 1'b1;
      rp_idx = 3'(best);
      sw_root = tbl[best].root;
      sw_cost = c[32] ? 32'hFFFF_FFFF : c[31:0];
    end else begin
      rp_valid = 1'b0;
      rp_idx = '0;
      sw_root = own_bridge;
      sw_cost = '0;
    end
    for (int i = 0; i < n; i++) begin
      if (rp_valid && i == rp_idx) continue;
      sv = '{sw_root, sw_cost, own_bridge, pid_of(i)};
      if (desig(i) || vcmp(sv, tbl[i]) < 0) tbl[i] = sv;
    end
  endtask

  always @(posedge clk) begin
    bpdu_t e;
    bpdu_t a;
    if (rst) begin
      lcost = 16'd1;
      prio = 8'd128;
      nports = 4'd8;
      own_bridge = '0;
      clear_table();
      bpdu_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BRIDGE: own_bridge = cfg_data;
          REG_COST:   lcost = cfg_data[15:0];
          REG_PRIO:   prio = cfg_data[7:0];
          REG_PORTS:  nports = cfg_data[3:0];
          default: ;
        endcase
        clear_table();
      end
      if (m_tvalid && m_tready) begin
        a = '{m_tdata[2:0], m_tdata[66:3], m_tdata[98:67], m_tdata[162:99],
              m_tdata[178:163], m_tlast};
        if (bpdu_q.size() == 0) begin
          if (errors < 10) $display("unexpected BPDU port %0d root %h", a.port, a.root);
          errors <= errors + 1;
        end else begin
          e = bpdu_q.pop_front();
          if (a != e) begin
            if (errors < 10)
              $display({"BPDU mismatch: exp p%0d r%h c%h b%h id%h l%b ",
                        "got p%0d r%h c%h b%h id%h l%b"},
                       e.port, e.root, e.cost, e.bridge, e.pid, e.last,
                       a.port, a.root, a.cost, a.bridge, a.pid, a.last);
            errors <= errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) predict_event(s_tuser, s_tdata);
    end
  end
endmodule
`default_nettype wire

/* sim/tb_spanning_tree_bpdu_engine.sv */
// Testbench top: drives events, configuration and output back-pressure; gives the verdict.
`default_nettype none
module tb_spanning_tree_bpdu_engine;
  import stp_pkg::*;

  logic            clk = 0;
  logic            rst = 1;
  logic            s_tvalid = 0;
  logic            s_tready;
  logic [TDW-1:0]  s_tdata = '0;
  logic            s_tuser = 0;
  logic            m_tvalid;
  logic            m_tready = 0;
  logic [TDW-1:0]  m_tdata;
  logic            m_tlast;
  logic            cfg_we = 0;
  logic [1:0]      cfg_index = REG_BRIDGE;
  logic [63:0]     cfg_data = '0;
  int              errors;
  int              pending;
  int              cycles = 0;
  bit              hold_off = 0;

  localparam logic FUNC_BPDU  = 1'b0;
  localparam logic FUNC_HELLO = 1'b1;
  localparam int   LIMIT = 400000;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  spanning_tree_bpdu_engine dut (.*);

  stp_bpdu_checker chk (.*);

  // vectors near the own bridge so the table sees both wins and losses
  logic [63:0] own_id;
  logic [7:0]  cur_prio;
  int          cur_ports;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays up after a beat unless a gap follows; settle drops it
  task automatic send_event(logic func, logic [2:0] p, logic [63:0] r, logic [31:0] c,
                            logic [63:0] b, logic [15:0] id);
    int g;
    g = gap_len();
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {5'd0, id, b, c, r, p};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] near_id();
    case ($urandom_range(0, 5))
      0: return own_id;
      1: return own_id - $urandom_range(1, 3);
      2: return own_id + $urandom_range(1, 3);
      3: return {$urandom, $urandom};
      4: return 64'd0;
      default: return 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] rnd_cost();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 2);
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  task automatic rnd_event();
    logic [15:0] id;
    if ($urandom_range(0, 3) == 0) begin
      send_event(FUNC_HELLO, 3'($urandom), {$urandom, $urandom}, $urandom,
                 {$urandom, $urandom}, 16'($urandom));
    end else begin
      id = $urandom_range(0, 1) ? {cur_prio, 8'($urandom_range(1, 8))} : 16'($urandom);
      send_event(FUNC_BPDU, 3'($urandom_range(0, 7)), near_id(), rnd_cost(),
                 $urandom_range(0, 2) == 0 ? own_id : near_id(), id);
    end
  endtask

  task automatic configure(logic [63:0] b, logic [15:0] c, logic [7:0] pr, logic [3:0] np);
    write_reg(REG_BRIDGE, b);
    write_reg(REG_COST, {48'd0, c});
    write_reg(REG_PRIO, {56'd0, pr});
    write_reg(REG_PORTS, {60'd0, np});
    cfg_we <= 1'b0;
    own_id = b;
    cur_prio = pr;
    cur_ports = np;
  endtask

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off) m_tready <= 1'b0;
    else m_tready <= $urandom_range(0, 9) < 7;
  end

  initial begin
    hold_off = 1;
    #0;
    forever begin
      @(posedge clk);
      if (cycles == 600) hold_off = 1;
      else if (cycles == 1200) hold_off = 0;
      else if (cycles > 1200) break;
      else if (cycles < 600) hold_off = 0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_spanning_tree_bpdu_engine: FAIL");
      $finish;
    end
  end

  initial begin
    own_id = 0;
    cur_prio = 8'd128;
    cur_ports = 8;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: reset state, then extremes
    send_event(FUNC_HELLO, 0, 0, 0, 0, 0);
    send_event(FUNC_BPDU, 7, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    settle();
    configure(64'h8000_0000_0000_0100, 16'hFFFF, 8'd255, 4'd8);
    send_event(FUNC_BPDU, 2, 64'h10, 32'hFFFF_FFF0, 64'h20, 16'h8001);   // saturating cost
    send_event(FUNC_HELLO, 0, 0, 0, 0, 0);
    send_event(FUNC_BPDU, 2, 64'h10, 32'hFFFF_FFF0, 64'h20, 16'h8001);   // equal vector
    send_event(FUNC_BPDU, 3, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);          // worse: answered
    send_event(FUNC_BPDU, 2, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);          // root port loses
    send_event(FUNC_HELLO, 0, 0, 0, 0, 0);
    settle();
    configure(64'h0, 16'd1, 8'd0, 4'd1);
    send_event(FUNC_BPDU, 5, 0, 0, 0, 0);                                // inactive port
    send_event(FUNC_BPDU, 0, 0, 0, 0, 0);
    send_event(FUNC_HELLO, 0, 0, 0, 0, 0);
    settle();
    configure(64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 8'd128, 4'd0);             // no active port
    send_event(FUNC_HELLO, 0, 0, 0, 0, 0);
    send_event(FUNC_BPDU, 0, 0, 0, 0, 0);
    settle();
    configure(64'h8000_0000_0000_0050, 16'd4, 8'd128, 4'd15);
    send_event(FUNC_BPDU, 1, 64'h8000_0000_0000_0010, 32'd3, 64'h8000_0000_0000_0011,
               16'h8002);
    send_event(FUNC_HELLO, 0, 0, 0, 0, 0);
    // random phases, the first under the long output hold-off
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        settle();
        configure({$urandom_range(0, 2) == 0 ? 16'hFFFF : 16'($urandom), 16'($urandom),
                   $urandom}, ph == 2 ? 16'hFFFF : 16'($urandom_range(1, 65535)),
                  8'($urandom), 4'($urandom_range(ph == 3 ? 1 : 2, 8)));
      end
      for (int k = 0; k < 50; k++) rnd_event();
    end
    settle();
    if (errors == 0) begin
      $display("tb_spanning_tree_bpdu_engine: PASS");
    end else begin
      $display("tb_spanning_tree_bpdu_engine: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
